@@ src/cpcd_pkg.sv @@
// Shared types and constants for the cassette pulse-count decoder.
// No dependencies; used by cpcd_decoder and cassette_pulse_count_decoder_top.
`timescale 1ns / 1ps
`default_nettype none

package cpcd_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SILENCE_THRESHOLD = 3'd0,
        REG_LONG_PULSE_MIN    = 3'd1,
        REG_SILENCE_RUN       = 3'd2,
        REG_STOP_PULSE_COUNT  = 3'd3,
        REG_DELIVER_MODE      = 3'd4
    } cpcd_reg_idx_t;

    localparam logic [15:0] SILENCE_THRESHOLD_RST = 16'd300;
    localparam logic [7:0]  LONG_PULSE_MIN_RST    = 8'd6;
    localparam logic [7:0]  SILENCE_RUN_RST       = 8'd10;
    localparam logic [15:0] STOP_PULSE_COUNT_RST  = 16'd4000;
    localparam logic        DELIVER_MODE_RST      = 1'b0;

    // Frame positions
    localparam logic [3:0]  AWAIT_START = 4'd15;
    localparam logic [3:0]  PARITY_POS  = 4'd8;
    localparam logic [3:0]  FIRST_DATA  = 4'd1;

    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

    // Delivery modes
    localparam logic MODE_DIRECT  = 1'b0;
    localparam logic OP_SAMPLE    = 1'b0;

    typedef struct packed {
        logic [15:0] silence_threshold;
        logic [7:0]  long_pulse_min;
        logic [7:0]  silence_run;
        logic [15:0] stop_pulse_count;
        logic        deliver_mode;
    } cpcd_cfg_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] byte_value;
        logic       parity_error;
        logic       error_latched;
        logic       start_bit_missing;
        logic       tape_stopped;
        logic       running;
    } cpcd_result_t;

endpackage

`default_nettype wire

@@ src/cpcd_decoder.sv @@
// Decoder state and combinational step logic for the cassette pulse-count decoder.
// Depends on cpcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpcd_decoder (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    step_en,
    input  wire logic                    op,
    input  wire logic signed [15:0]      sample,
    input  wire cpcd_pkg::cpcd_cfg_t     cfg,
    output cpcd_pkg::cpcd_result_t       result
);

    logic signed [15:0] prev_sample_reg, prev_sample_next;
    logic [15:0]        silence_count_reg, silence_count_next;
    logic [15:0]        pulse_count_reg, pulse_count_next;
    logic [3:0]         bit_pos_reg, bit_pos_next;
    logic               ones_odd_reg, ones_odd_next;
    logic [7:0]         data_shift_reg, data_shift_next;
    logic               tape_running_reg, tape_running_next;
    logic               error_flag_reg, error_flag_next;

    logic signed [16:0] diff;
    logic [15:0]        abs_diff;
    logic               crossing;
    logic               burst_end;
    logic               is_long;
    logic               valid;
    logic [7:0]         value;
    logic               perr;
    logic               missing;
    logic               stopped;

    assign diff     = 17'(signed'(sample)) - 17'(signed'(prev_sample_reg));
    assign abs_diff = diff[16] ? 16'(-diff) : diff[15:0];
    assign crossing = (prev_sample_reg <= 16'sd0) ? (sample > 16'sd0) : (sample < 16'sd0);

    always_comb begin
        prev_sample_next   = prev_sample_reg;
        silence_count_next = silence_count_reg;
        pulse_count_next   = pulse_count_reg;
        bit_pos_next       = bit_pos_reg;
        ones_odd_next      = ones_odd_reg;
        data_shift_next    = data_shift_reg;
        tape_running_next  = tape_running_reg;
        error_flag_next    = error_flag_reg;
        burst_end          = 1'b0;
        is_long            = 1'b0;
        valid              = 1'b0;
        value              = 8'd0;
        perr               = 1'b0;
        missing            = 1'b0;
        stopped            = 1'b0;

        if (op != cpcd_pkg::OP_SAMPLE) begin
            if (!tape_running_reg) begin
                prev_sample_next   = 16'sd0;
                silence_count_next = 16'd0;
                pulse_count_next   = 16'd0;
                bit_pos_next       = cpcd_pkg::AWAIT_START;
                ones_odd_next      = 1'b0;
                data_shift_next    = 8'd0;
                tape_running_next  = 1'b1;
            end
        end else if (tape_running_reg) begin
            if (abs_diff < cfg.silence_threshold) begin
                if (silence_count_reg != cpcd_pkg::COUNT_MAX) begin
                    silence_count_next = silence_count_reg + 16'd1;
                end
            end else begin
                silence_count_next = 16'd0;
            end

            if (crossing && silence_count_next == 16'd0
                    && pulse_count_reg != cpcd_pkg::COUNT_MAX) begin
                pulse_count_next = pulse_count_reg + 16'd1;
            end

            if (pulse_count_next > cfg.stop_pulse_count
                    && silence_count_next > {8'd0, cfg.silence_run}) begin
                tape_running_next = 1'b0;
                stopped           = 1'b1;
            end

            burst_end = (pulse_count_next > 16'd1)
                     && (silence_count_next > {8'd0, cfg.silence_run});
            is_long   = pulse_count_next > {8'd0, cfg.long_pulse_min};

            if (burst_end) begin
                if (bit_pos_reg == cpcd_pkg::PARITY_POS) begin
                    ones_odd_next   = 1'b0;
                    data_shift_next = 8'd0;
                    if (is_long && !ones_odd_reg) begin
                        error_flag_next = 1'b1;
                        perr            = 1'b1;
                        valid           = (cfg.deliver_mode == cpcd_pkg::MODE_DIRECT);
                        bit_pos_next    = cpcd_pkg::FIRST_DATA;
                    end else begin
                        valid        = 1'b1;
                        value        = data_shift_reg;
                        bit_pos_next = cpcd_pkg::AWAIT_START;
                    end
                end else begin
                    if (bit_pos_reg != cpcd_pkg::AWAIT_START) begin
                        if (is_long) begin
                            data_shift_next = data_shift_reg | (8'd1 << bit_pos_reg[2:0]);
                        end
                        bit_pos_next = bit_pos_reg + 4'd1;
                    end else if (!is_long) begin
                        // short start bit: treat it as data bit zero
                        missing      = 1'b1;
                        bit_pos_next = cpcd_pkg::FIRST_DATA;
                    end else begin
                        bit_pos_next = bit_pos_reg + 4'd1;
                    end
                    if (is_long) begin
                        ones_odd_next = ~ones_odd_reg;
                    end
                end
                pulse_count_next = 16'd0;
            end
            prev_sample_next = sample;
        end
    end

    always_comb begin
        result.byte_valid        = valid;
        result.byte_value        = valid ? value : 8'd0;
        result.parity_error      = perr;
        result.error_latched     = error_flag_next;
        result.start_bit_missing = missing;
        result.tape_stopped      = stopped;
        result.running           = tape_running_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_sample_reg   <= 16'sd0;
            silence_count_reg <= 16'd0;
            pulse_count_reg   <= 16'd0;
            bit_pos_reg       <= cpcd_pkg::AWAIT_START;
            ones_odd_reg      <= 1'b0;
            data_shift_reg    <= 8'd0;
            tape_running_reg  <= 1'b0;
            error_flag_reg    <= 1'b0;
        end else if (step_en) begin
            prev_sample_reg   <= prev_sample_next;
            silence_count_reg <= silence_count_next;
            pulse_count_reg   <= pulse_count_next;
            bit_pos_reg       <= bit_pos_next;
            ones_odd_reg      <= ones_odd_next;
            data_shift_reg    <= data_shift_next;
            tape_running_reg  <= tape_running_next;
            error_flag_reg    <= error_flag_next;
        end
    end

endmodule

`default_nettype wire

@@ src/cassette_pulse_count_decoder_top.sv @@
// Top level of the cassette pulse-count decoder: config registers, decoder, output skid.
// Depends on cpcd_pkg and cpcd_decoder.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Payload
// s_        in         s_valid / s_ready        s_op, s_sample
// m_        out        m_valid / m_ready        m_byte_valid .. m_running (one beat per s_ beat)
// cfg_      in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One beat enters per cycle while s_ready is high; its result beat is registered for m_.
// The whole decode step is one pass of compare-and-count logic ahead of the output register.
// An output register plus one skid entry decouple the two sides: s_ready only drops once
// two result beats are waiting. Synchronous active-low reset clears decoder state, both
// output entries and restores the register defaults; cfg_ready is always high.

module cassette_pulse_count_decoder_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_op,
    input  wire logic signed [15:0] s_sample,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_byte_valid,
    output logic [7:0]              m_byte_value,
    output logic                    m_parity_error,
    output logic                    m_error_latched,
    output logic                    m_start_bit_missing,
    output logic                    m_tape_stopped,
    output logic                    m_running,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    cpcd_pkg::cpcd_cfg_t    cfg_reg;
    cpcd_pkg::cpcd_result_t step_result;
    cpcd_pkg::cpcd_result_t out_reg;
    cpcd_pkg::cpcd_result_t skid_reg;
    logic                   out_valid_reg;
    logic                   skid_valid_reg;
    logic                   s_accept;
    logic                   out_free;

    // Config writes go straight into the config register; never stall them.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.silence_threshold <= cpcd_pkg::SILENCE_THRESHOLD_RST;
            cfg_reg.long_pulse_min    <= cpcd_pkg::LONG_PULSE_MIN_RST;
            cfg_reg.silence_run       <= cpcd_pkg::SILENCE_RUN_RST;
            cfg_reg.stop_pulse_count  <= cpcd_pkg::STOP_PULSE_COUNT_RST;
            cfg_reg.deliver_mode      <= cpcd_pkg::DELIVER_MODE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cpcd_pkg::cpcd_reg_idx_t'(cfg_index))
                cpcd_pkg::REG_SILENCE_THRESHOLD: cfg_reg.silence_threshold <= cfg_data;
                cpcd_pkg::REG_LONG_PULSE_MIN:    cfg_reg.long_pulse_min    <= cfg_data[7:0];
                cpcd_pkg::REG_SILENCE_RUN:       cfg_reg.silence_run       <= cfg_data[7:0];
                cpcd_pkg::REG_STOP_PULSE_COUNT:  cfg_reg.stop_pulse_count  <= cfg_data;
                cpcd_pkg::REG_DELIVER_MODE:      cfg_reg.deliver_mode      <= cfg_data[0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // Accept while the skid entry is empty; the decoder advances on every accepted beat.
    assign s_ready  = !skid_valid_reg;
    assign s_accept = s_valid && s_ready;

    cpcd_decoder u_decoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (s_accept),
        .op      (s_op),
        .sample  (s_sample),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    // Output register drains first; skid holds a beat that arrived during a stall.
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= s_accept;
            end
        end else if (s_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (s_accept) begin
                out_reg <= step_result;
            end
        end else if (s_accept) begin
            skid_reg <= step_result;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_byte_valid        = out_reg.byte_valid;
    assign m_byte_value        = out_reg.byte_value;
    assign m_parity_error      = out_reg.parity_error;
    assign m_error_latched     = out_reg.error_latched;
    assign m_start_bit_missing = out_reg.start_bit_missing;
    assign m_tape_stopped      = out_reg.tape_stopped;
    assign m_running           = out_reg.running;

    // Skid entry is only filled behind a stalled output register.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // A parity error always leaves the sticky flag set.
    a_perr_latches: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_parity_error) |-> m_error_latched)
        else $error("parity error without latched error flag");

    // Stopping the tape leaves it not running.
    a_stop_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_tape_stopped) |-> !m_running)
        else $error("tape stopped but still running");

    // No byte value shown without a delivered byte.
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_byte_valid) |-> (m_byte_value == 8'd0))
        else $error("byte value nonzero without byte_valid");

endmodule

`default_nettype wire
